[src/crc32br_pkg.sv]
// Shared constants and types for the byte-wise reflected CRC-32 block.
`default_nettype none

package crc32br_pkg;

   // Reflected CRC-32 polynomial and the all-ones preset and final mask.
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // One message byte with its framing marks, as held in the input register.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_word_type;

endpackage : crc32br_pkg

`default_nettype wire

[src/crc32_bytewise_reversed.sv]
// Top level of the byte-wise reflected CRC-32 with bit-reversed checksum output.
// A byte is registered in the input register on acceptance and folded from there;
// a last byte's checksum word then goes through the result register to rsp_valid.
// Throughput: one byte per cycle unless stalled, set by the combinational update
// into the CRC register; a last byte meeting a stalled result word stalls the input.
// Reset: synchronous, active high; the CRC register returns to all ones, the
// final inversion is set, and both the input and result registers are emptied.
`default_nettype none

module crc32_bytewise_reversed (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_checksum
);
   import crc32br_pkg::*;

   logic         final_invert_ff;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_word_ff;
   logic [31:0]  crc_ff;
   logic [31:0]  crc_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic [31:0]  out_checksum_ff;
   logic [31:0]  out_checksum_in;
   logic [31:0]  crc_next;
   logic [31:0]  checksum_next;
   logic         req_fire;
   logic         rsp_fire;
   logic         s1_fire;
   logic         s1_emit;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         final_invert_ff <= 1'b1;
      end else if (csr_write_enable) begin
         final_invert_ff <= csr_write_data;
      end
   end

   // Byte update logic between the input register and the CRC/result registers.
   crc32br_byte_update u_byte_update (
      .word_i         (s1_word_ff),
      .crc_i          (crc_ff),
      .final_invert_i (final_invert_ff),
      .crc_next_o     (crc_next),
      .checksum_o     (checksum_next)
   );

   // The held byte moves on unless it is a last byte and the result slot stays full.
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_word_ff.last_byte || !out_valid_ff || !rsp_stall);
   assign s1_emit   = s1_fire && s1_word_ff.last_byte;
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;

   // Next values of the pipeline control and the CRC register.
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      crc_in          = crc_ff;
      out_valid_in    = out_valid_ff;
      out_checksum_in = out_checksum_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         crc_in      = crc_next;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
      if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
      if (s1_emit) begin
         out_valid_in    = 1'b1;
         out_checksum_in = checksum_next;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         crc_ff       <= CRC_ALL_ONES;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff <= '{data_byte: req_data_byte, first_byte: req_first_byte,
                         last_byte: req_last_byte};
      end
      out_checksum_ff <= out_checksum_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_checksum = out_checksum_ff;

   // The input side is held back only by a last byte waiting on a full result slot.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_word_ff.last_byte && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked last byte");

   // A folded last byte always shows up as a result word in the next cycle.
   a_emit_result : assert property (@(posedge clock) disable iff (reset)
      s1_emit |=> (rsp_valid && rsp_checksum == $past(checksum_next)))
      else $error("last byte did not produce its checksum word");

   // A byte that is not last leaves the result register untouched.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !s1_emit) |=> !rsp_valid)
      else $error("result word appeared without a last byte");

   // Reset restarts the CRC from all ones with both stages empty.
   a_reset_state : assert property (@(posedge clock)
      reset |=> (crc_ff == CRC_ALL_ONES && !s1_valid_ff && !rsp_valid))
      else $error("state not cleared by reset");

endmodule : crc32_bytewise_reversed

`default_nettype wire

[src/crc32br_byte_update.sv]
// Combinational byte update of the CRC register and the checksum output mapping.
`default_nettype none

module crc32br_byte_update (
   input  wire crc32br_pkg::req_word_type word_i,
   input  wire logic [31:0]               crc_i,
   input  wire logic                      final_invert_i,
   output logic [31:0]                    crc_next_o,
   output logic [31:0]                    checksum_o
);
   import crc32br_pkg::*;

   logic [31:0] start;
   logic [31:0] stage;
   logic [31:0] reversed;

   // A first byte restarts the register from all ones.
   assign start = word_i.first_byte ? CRC_ALL_ONES : crc_i;

   // Fold the byte in LSB first: one shift and conditional XOR per bit.
   always_comb begin
      stage = start ^ {24'd0, word_i.data_byte};
      for (int k = 0; k < 8; k++) begin
         if (stage[0]) begin
            stage = (stage >> 1) ^ CRC_POLY;
         end else begin
            stage = stage >> 1;
         end
      end
   end

   assign crc_next_o = stage;

   // The checksum is the updated register with its bit order reversed, inverted when final inversion is set.
   always_comb begin
      for (int k = 0; k < 32; k++) begin
         reversed[k] = stage[31 - k];
      end
   end

   assign checksum_o = final_invert_i ? (reversed ^ CRC_ALL_ONES) : reversed;

endmodule : crc32br_byte_update

`default_nettype wire
